FILE: rtl/exttmr_pkg.sv
// Package for the extended timer: constants, operation codes and request/result types.
package exttmr_pkg;

  // Fraction bits of the Q48.16 time format
  localparam int Q_FRAC = 16;

  // Default configuration of the timer
  localparam int COUNTER_BITS_DEF = 32;
  localparam int SUBSEC_BITS_DEF  = 15;

  // Operation codes
  localparam logic [1:0] OP_TICK        = 2'd0;
  localparam logic [1:0] OP_SET_TIME    = 2'd1;
  localparam logic [1:0] OP_SET_ALARM   = 2'd2;
  localparam logic [1:0] OP_CLEAR_ALARM = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] time_value;
  } req_t;

  typedef struct packed {
    logic [63:0] current_time;
    logic [63:0] alarm_time;
    logic        alarm_fire;
  } rsp_t;

endpackage

FILE: rtl/extended_timer_with_alarm_top.sv
// Top level of the extended timer with alarm: step core plus a two-entry result buffer.
// A result is registered in the output register, or in the skid entry while the output
//   is stalled. Throughput: one request per cycle while req_stall is low; the result
//   register plus a skid entry let a request be taken while one result waits.
// Reset (rst, synchronous): counter, wrap count, alarm and arming clear to zero, the
//   result buffer empties; requests are taken from the first cycle after reset.
module extended_timer_with_alarm_top import exttmr_pkg::*; #(
  parameter int COUNTER_BITS = COUNTER_BITS_DEF,
  parameter int SUBSEC_BITS  = SUBSEC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  // request channel
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  // result channel
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  logic accept;
  logic taken;
  rsp_t rsp_next;

  // skid entry holds a result computed while the output register was stalled
  logic skid_valid;
  rsp_t skid;

  assign req_stall = skid_valid;
  assign accept    = req_valid && !skid_valid;
  assign taken     = rsp_valid && !rsp_stall;

  exttmr_core #(
    .COUNTER_BITS (COUNTER_BITS),
    .SUBSEC_BITS  (SUBSEC_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .req      (req),
    .rsp_next (rsp_next)
  );

  // Output register and skid control
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      priority if (taken) begin
        if (skid_valid) begin
          skid_valid <= 1'b0;        // drain the waiting result
        end else begin
          rsp_valid <= accept;       // refill or go empty
        end
      end else if (!rsp_valid) begin
        rsp_valid <= accept;
      end else if (accept) begin
        skid_valid <= 1'b1;          // output stalled: park the new result
      end
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (taken && skid_valid) begin
      rsp <= skid;
    end else if (accept && (taken || !rsp_valid)) begin
      rsp <= rsp_next;
    end
    if (accept && rsp_valid && !taken) begin
      skid <= rsp_next;
    end
  end

endmodule

FILE: rtl/exttmr_core.sv
// Timer state and step logic for tick, set time, set alarm and clear alarm.
module exttmr_core import exttmr_pkg::*; #(
  parameter int COUNTER_BITS = COUNTER_BITS_DEF,
  parameter int SUBSEC_BITS  = SUBSEC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic accept,
  input  req_t req,
  output rsp_t rsp_next
);

  localparam int SHIFT = Q_FRAC - SUBSEC_BITS;

  logic [COUNTER_BITS-1:0] tick_count, tick_count_next;
  logic [31:0]             wrap_count, wrap_count_next;
  logic [COUNTER_BITS-1:0] alarm_low, alarm_low_next;
  logic [31:0]             alarm_epoch, alarm_epoch_next;
  logic                    alarm_pending, alarm_pending_next;
  logic                    compare_armed, compare_armed_next;
  logic                    fire;

  logic [63:0]             scaled;
  logic [COUNTER_BITS-1:0] new_low;
  logic [31:0]             new_high;
  logic [COUNTER_BITS-1:0] tick_inc;
  logic [31:0]             wrap_inc;
  logic                    armed_mid;

  assign scaled   = req.time_value >> SHIFT;
  assign new_low  = scaled[COUNTER_BITS-1:0];
  assign new_high = scaled[COUNTER_BITS +: 32];
  assign tick_inc = tick_count + {{(COUNTER_BITS-1){1'b0}}, 1'b1};
  assign wrap_inc = wrap_count + 32'd1;

  always_comb begin
    tick_count_next    = tick_count;
    wrap_count_next    = wrap_count;
    alarm_low_next     = alarm_low;
    alarm_epoch_next   = alarm_epoch;
    alarm_pending_next = alarm_pending;
    compare_armed_next = compare_armed;
    fire               = 1'b0;
    armed_mid          = compare_armed;
    unique case (req.opcode)
      OP_TICK: begin
        tick_count_next = tick_inc;
        if (tick_inc == '0) begin
          wrap_count_next = wrap_inc;
          // wrap into the alarm's epoch: arm, or fire now for a zero low part
          if (alarm_pending && alarm_epoch == wrap_inc) begin
            if (alarm_low != '0) armed_mid = 1'b1;
            else fire = 1'b1;
          end
        end
        compare_armed_next = armed_mid;
        if (armed_mid && tick_inc == alarm_low) begin
          fire               = 1'b1;
          compare_armed_next = 1'b0;
        end
      end
      OP_SET_TIME: begin
        tick_count_next = new_low;
        wrap_count_next = new_high;
      end
      OP_SET_ALARM: begin
        alarm_low_next     = new_low;
        alarm_epoch_next   = new_high;
        alarm_pending_next = 1'b1;
        compare_armed_next = 1'b0;
        if (new_high == wrap_count) begin
          if (tick_count == new_low) fire = 1'b1;
          else if (tick_count < new_low) compare_armed_next = 1'b1;
        end
      end
      OP_CLEAR_ALARM: begin
        alarm_pending_next = 1'b0;
        compare_armed_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // rebuild Q48.16 values from the next state
  assign rsp_next.current_time = 64'({wrap_count_next, tick_count_next}) << SHIFT;
  assign rsp_next.alarm_time   = 64'({alarm_epoch_next, alarm_low_next}) << SHIFT;
  assign rsp_next.alarm_fire   = fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count    <= '0;
      wrap_count    <= '0;
      alarm_low     <= '0;
      alarm_epoch   <= '0;
      alarm_pending <= 1'b0;
      compare_armed <= 1'b0;
    end else if (accept) begin
      tick_count    <= tick_count_next;
      wrap_count    <= wrap_count_next;
      alarm_low     <= alarm_low_next;
      alarm_epoch   <= alarm_epoch_next;
      alarm_pending <= alarm_pending_next;
      compare_armed <= compare_armed_next;
    end
  end

endmodule
